@@ rtl/core/mqttd_pkg.sv @@
// shared types and constants for the mqtt packet deframer
package mqttd_pkg;

    localparam int          LP_MAX_LEN_BYTES = 4;
    localparam int          LP_QUEUE_DEPTH   = 2;
    localparam logic [27:0] LP_CAP_RESET     = 28'd2048;
    localparam logic [3:0]  PKT_PUBLISH      = 4'h3;

    typedef enum logic [2:0] {
        PART_TYPE      = 3'd0,
        PART_LENGTH    = 3'd1,
        PART_TOPIC_LEN = 3'd2,
        PART_TOPIC     = 3'd3,
        PART_PAYLOAD   = 3'd4,
        PART_OTHER     = 3'd5,
        PART_MALFORMED = 3'd6,
        PART_HALTED    = 3'd7
    } t_part;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_CAPACITY = 2'd1,
        ERR_OVERRUN  = 2'd2
    } t_err;

    typedef enum logic [2:0] {
        PH_TYPE     = 3'd0,
        PH_LEN      = 3'd1,
        PH_TLEN_HI  = 3'd2,
        PH_TLEN_LO  = 3'd3,
        PH_TOPIC    = 3'd4,
        PH_PAYLOAD  = 3'd5,
        PH_OTHER    = 3'd6,
        PH_BAD      = 3'd7
    } t_phase;

    // classified byte handed from front to back
    typedef struct packed {
        logic [7:0] data;
        logic       cont;
        logic       is_publish;
    } t_cmd;

    typedef struct packed {
        logic [7:0]  data_byte;
        t_part       byte_part;
        logic [3:0]  packet_type;
        logic [3:0]  packet_flags;
        logic [27:0] body_length;
        logic [15:0] topic_length;
        logic        end_of_packet;
        t_err        error_code;
    } t_result;

endpackage

@@ rtl/core/mqtt_packet_deframer_core.sv @@
// mqtt fixed-header deframer top level: config register, front end and back end
// a byte taken into the byte queue is classified by the state machine, written into the
// result queue and shown on the result ports from there; a full result queue holds it back
// throughput: one byte per cycle while the result queue has room, set by the back end state update
// reset: synchronous, active low; clears both queues and all packet state, and sets
// body_capacity to 2048; no clearing pass, the block takes bytes right after reset
module mqtt_packet_deframer_core
    import mqttd_pkg::*;
#(
    parameter int QUEUE_DEPTH = LP_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_rx_byte,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_data_byte,
    output logic [2:0]  o_byte_part,
    output logic [3:0]  o_packet_type,
    output logic [3:0]  o_packet_flags,
    output logic [27:0] o_body_length,
    output logic [15:0] o_topic_length,
    output logic        o_end_of_packet,
    output logic [1:0]  o_error_code,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam logic REG_BODY_CAPACITY = 1'b0;

    logic [27:0] r_capacity;
    t_cmd        cmd;
    logic        cmd_valid;
    logic        cmd_pop;
    t_result     res;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_BODY_CAPACITY) ? {4'h0, r_capacity} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= LP_CAP_RESET;
        end else if (psel && penable && pwrite && pready
                     && (paddr[2] == REG_BODY_CAPACITY)) begin
            r_capacity <= pwdata[27:0];
        end
    end

    mqttd_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_rx_byte   (i_rx_byte),
        .o_full      (full),
        .o_cmd       (cmd),
        .o_cmd_valid (cmd_valid),
        .i_cmd_pop   (cmd_pop)
    );

    mqttd_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cmd_valid (cmd_valid),
        .o_cmd_pop   (cmd_pop),
        .i_capacity  (r_capacity),
        .i_res_pop   (pop),
        .o_res       (res),
        .o_res_empty (empty)
    );

    assign o_data_byte     = res.data_byte;
    assign o_byte_part     = res.byte_part;
    assign o_packet_type   = res.packet_type;
    assign o_packet_flags  = res.packet_flags;
    assign o_body_length   = res.body_length;
    assign o_topic_length  = res.topic_length;
    assign o_end_of_packet = res.end_of_packet;
    assign o_error_code    = res.error_code;

`ifndef SYNTHESIS
    // once halted, every later item stays halted
    a_halt_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && o_byte_part == PART_HALTED)
        |=> (empty || o_byte_part == PART_HALTED))
        else $error("halted item followed by a non-halted item");

    // a capacity error never closes a packet
    a_cap_no_eop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_error_code == ERR_CAPACITY) |-> !o_end_of_packet)
        else $error("capacity error item marked as end of packet");

    // the type byte opens a packet cleanly
    a_type_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_byte_part == PART_TYPE)
        |-> (!o_end_of_packet && o_error_code == ERR_NONE
             && o_body_length == '0 && o_topic_length == '0))
        else $error("type byte item carries stale packet state");
`endif

endmodule

@@ rtl/core/mqttd_fifo.sv @@
// small register queue with push/full and pop/empty sides
module mqttd_fifo
    import mqttd_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = LP_QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             wr_en, rd_en;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + CW'(1);
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

@@ rtl/core/mqttd_front.sv @@
// front end: takes stream bytes, classifies them and queues them for the back end
module mqttd_front
    import mqttd_pkg::*;
#(
    parameter int QUEUE_DEPTH = LP_QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic [7:0] i_rx_byte,
    output logic       o_full,
    output t_cmd       o_cmd,
    output logic       o_cmd_valid,
    input  logic       i_cmd_pop
);
    t_cmd cmd_in;
    logic cmd_empty;

    always_comb begin
        cmd_in.data       = i_rx_byte;
        cmd_in.cont       = i_rx_byte[7];
        cmd_in.is_publish = (i_rx_byte[7:4] == PKT_PUBLISH);
    end

    mqttd_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (cmd_in),
        .o_full  (o_full),
        .i_pop   (i_cmd_pop),
        .o_data  (o_cmd),
        .o_empty (cmd_empty)
    );

    assign o_cmd_valid = !cmd_empty;

endmodule

@@ rtl/core/mqttd_back.sv @@
// back end: packet state machine and result queue
module mqttd_back
    import mqttd_pkg::*;
#(
    parameter int QUEUE_DEPTH = LP_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic        i_cmd_valid,
    output logic        o_cmd_pop,
    input  logic [27:0] i_capacity,
    input  logic        i_res_pop,
    output t_result     o_res,
    output logic        o_res_empty
);
    t_phase      r_phase, n_phase;
    logic [7:0]  r_header, n_header;
    logic        r_is_pub, n_is_pub;
    logic [27:0] r_len_acc, n_len_acc;
    logic [2:0]  r_len_cnt, n_len_cnt;
    logic [27:0] r_body_left, n_body_left;
    logic [15:0] r_topic_len, n_topic_len;
    logic [15:0] r_topic_left, n_topic_left;
    logic        r_halted, n_halted;

    t_result     res;
    logic        res_full;
    logic        fire;

    logic [4:0]  len_shift;
    logic [27:0] len_sum;
    logic [2:0]  cnt_inc;
    logic        len_done;
    logic        over_cap;
    logic [27:0] body_dec;
    logic        body_last;
    logic [15:0] tlen_full;
    logic        topic_over;
    logic [15:0] topic_dec;

    assign fire      = i_cmd_valid && !res_full;
    assign o_cmd_pop = fire;

    // shared datapath terms
    assign len_shift  = {3'b000, r_len_cnt[1:0]} * 5'd7;
    assign len_sum    = r_len_acc + (28'(i_cmd.data[6:0]) << len_shift);
    assign cnt_inc    = r_len_cnt + 3'd1;
    assign len_done   = !i_cmd.cont || (cnt_inc >= 3'(LP_MAX_LEN_BYTES));
    assign over_cap   = (len_sum > i_capacity);
    assign body_dec   = (r_body_left != '0) ? r_body_left - 28'd1 : r_body_left;
    assign body_last  = (body_dec == '0);
    assign tlen_full  = r_topic_len | {8'h00, i_cmd.data};
    assign topic_over = ({12'h000, tlen_full} > body_dec);
    assign topic_dec  = (r_topic_left != '0) ? r_topic_left - 16'd1 : r_topic_left;

    // next state
    always_comb begin
        n_phase = r_phase;
        if (fire && !r_halted) begin
            unique case (r_phase)
                PH_TYPE: n_phase = PH_LEN;
                PH_LEN: begin
                    if (len_done && !over_cap) begin
                        if (len_sum == '0) begin
                            n_phase = PH_TYPE;
                        end else if (r_is_pub) begin
                            n_phase = (len_sum < 28'd2) ? PH_BAD : PH_TLEN_HI;
                        end else begin
                            n_phase = PH_OTHER;
                        end
                    end
                end
                PH_TLEN_HI: n_phase = body_last ? PH_TYPE : PH_TLEN_LO;
                PH_TLEN_LO: begin
                    if (body_last) begin
                        n_phase = PH_TYPE;
                    end else if (topic_over) begin
                        n_phase = PH_BAD;
                    end else begin
                        n_phase = (tlen_full != '0) ? PH_TOPIC : PH_PAYLOAD;
                    end
                end
                PH_TOPIC: begin
                    if (body_last) begin
                        n_phase = PH_TYPE;
                    end else if (topic_dec == '0) begin
                        n_phase = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: n_phase = body_last ? PH_TYPE : PH_PAYLOAD;
                PH_OTHER:   n_phase = body_last ? PH_TYPE : PH_OTHER;
                PH_BAD:     n_phase = body_last ? PH_TYPE : PH_BAD;
            endcase
        end
    end

    // datapath updates and result tag
    always_comb begin
        n_header     = r_header;
        n_is_pub     = r_is_pub;
        n_len_acc    = r_len_acc;
        n_len_cnt    = r_len_cnt;
        n_body_left  = r_body_left;
        n_topic_len  = r_topic_len;
        n_topic_left = r_topic_left;
        n_halted     = r_halted;
        res.byte_part     = PART_HALTED;
        res.error_code    = ERR_CAPACITY;
        res.end_of_packet = 1'b0;
        if (!r_halted) begin
            res.error_code = ERR_NONE;
            unique case (r_phase)
                PH_TYPE: begin
                    res.byte_part = PART_TYPE;
                    n_header      = i_cmd.data;
                    n_is_pub      = i_cmd.is_publish;
                    n_len_acc     = '0;
                    n_len_cnt     = '0;
                    n_body_left   = '0;
                    n_topic_len   = '0;
                    n_topic_left  = '0;
                end
                PH_LEN: begin
                    res.byte_part = PART_LENGTH;
                    n_len_acc     = len_sum;
                    n_len_cnt     = cnt_inc;
                    if (len_done) begin
                        if (over_cap) begin
                            res.error_code = ERR_CAPACITY;
                            n_halted       = 1'b1;
                        end else if (len_sum == '0) begin
                            res.end_of_packet = 1'b1;
                        end else begin
                            n_body_left = len_sum;
                        end
                    end
                end
                PH_TLEN_HI: begin
                    res.byte_part     = PART_TOPIC_LEN;
                    n_topic_len       = {i_cmd.data, 8'h00};
                    n_body_left       = body_dec;
                    res.end_of_packet = body_last;
                end
                PH_TLEN_LO: begin
                    res.byte_part     = PART_TOPIC_LEN;
                    n_topic_len       = tlen_full;
                    n_body_left       = body_dec;
                    res.end_of_packet = body_last;
                    if (topic_over) begin
                        res.error_code = ERR_OVERRUN;
                    end else if (!body_last) begin
                        n_topic_left = tlen_full;
                    end
                end
                PH_TOPIC: begin
                    res.byte_part     = PART_TOPIC;
                    n_topic_left      = topic_dec;
                    n_body_left       = body_dec;
                    res.end_of_packet = body_last;
                end
                PH_PAYLOAD: begin
                    res.byte_part     = PART_PAYLOAD;
                    n_body_left       = body_dec;
                    res.end_of_packet = body_last;
                end
                PH_OTHER: begin
                    res.byte_part     = PART_OTHER;
                    n_body_left       = body_dec;
                    res.end_of_packet = body_last;
                end
                PH_BAD: begin
                    res.byte_part     = PART_MALFORMED;
                    res.error_code    = ERR_OVERRUN;
                    n_body_left       = body_dec;
                    res.end_of_packet = body_last;
                end
            endcase
        end
        res.data_byte    = i_cmd.data;
        res.packet_type  = n_header[7:4];
        res.packet_flags = n_header[3:0];
        res.body_length  = n_len_acc;
        res.topic_length = n_topic_len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_TYPE;
            r_header     <= '0;
            r_is_pub     <= 1'b0;
            r_len_acc    <= '0;
            r_len_cnt    <= '0;
            r_body_left  <= '0;
            r_topic_len  <= '0;
            r_topic_left <= '0;
            r_halted     <= 1'b0;
        end else if (fire) begin
            r_phase      <= n_phase;
            r_header     <= n_header;
            r_is_pub     <= n_is_pub;
            r_len_acc    <= n_len_acc;
            r_len_cnt    <= n_len_cnt;
            r_body_left  <= n_body_left;
            r_topic_len  <= n_topic_len;
            r_topic_left <= n_topic_left;
            r_halted     <= n_halted;
        end
    end

    mqttd_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fire),
        .i_data  (res),
        .o_full  (res_full),
        .i_pop   (i_res_pop),
        .o_data  (o_res),
        .o_empty (o_res_empty)
    );

endmodule

@@ verif/mqttd_tag_checker.sv @@
// checker for the mqtt deframer: predicts the tag of every accepted byte and compares results
`timescale 1ns / 100ps

module mqttd_tag_checker
    import mqttd_pkg::*;
#(
    parameter logic [2:0] CAP_ADDR = 3'd0
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic        i_full,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_empty,
    input  logic        i_pop,
    input  t_result     i_tag,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_pready,
    output int          o_fail_count,
    output int          o_pending
);

    // predictor copy of the deframer state
    logic [27:0] body_capacity;
    t_phase      st_phase;
    logic [7:0]  hdr_byte;
    logic [27:0] len_acc;
    logic [2:0]  len_cnt;
    logic [27:0] body_left;
    logic [15:0] topic_len;
    logic [15:0] topic_left;
    logic        is_halted;

    t_result expected_tags[$];
    t_result want;
    int      fail_total = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic logic count_body_byte();
        if (body_left > 0)
            body_left = body_left - 1;
        if (body_left == 0) begin
            st_phase = PH_TYPE;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic t_result predict_tag(input logic [7:0] b);
        t_result r;
        t_part   part;
        t_err    err;
        logic    last;
        part = PART_TYPE;
        err  = ERR_NONE;
        last = 1'b0;
        if (is_halted) begin
            part = PART_HALTED;
            err  = ERR_CAPACITY;
        end else begin
            case (st_phase)
                PH_TYPE: begin
                    hdr_byte   = b;
                    len_acc    = '0;
                    len_cnt    = '0;
                    body_left  = '0;
                    topic_len  = '0;
                    topic_left = '0;
                    st_phase   = PH_LEN;
                end
                PH_LEN: begin
                    part    = PART_LENGTH;
                    len_acc = len_acc + (28'(b[6:0]) << (7 * len_cnt[1:0]));
                    len_cnt = len_cnt + 3'd1;
                    // length is final on a clear continuation bit or the last allowed byte
                    if (!b[7] || len_cnt >= LP_MAX_LEN_BYTES) begin
                        if (len_acc > body_capacity) begin
                            err       = ERR_CAPACITY;
                            is_halted = 1'b1;
                        end else if (len_acc == 0) begin
                            last     = 1'b1;
                            st_phase = PH_TYPE;
                        end else begin
                            body_left = len_acc;
                            if (hdr_byte[7:4] == PKT_PUBLISH)
                                st_phase = (len_acc < 28'd2) ? PH_BAD : PH_TLEN_HI;
                            else
                                st_phase = PH_OTHER;
                        end
                    end
                end
                PH_TLEN_HI: begin
                    part      = PART_TOPIC_LEN;
                    topic_len = {b, 8'h00};
                    last      = count_body_byte();
                    if (!last)
                        st_phase = PH_TLEN_LO;
                end
                PH_TLEN_LO: begin
                    part      = PART_TOPIC_LEN;
                    topic_len = topic_len | 16'(b);
                    last      = count_body_byte();
                    if (28'(topic_len) > body_left) begin
                        err = ERR_OVERRUN;
                        if (!last)
                            st_phase = PH_BAD;
                    end else if (!last) begin
                        topic_left = topic_len;
                        st_phase   = (topic_len > 0) ? PH_TOPIC : PH_PAYLOAD;
                    end
                end
                PH_TOPIC: begin
                    part = PART_TOPIC;
                    if (topic_left > 0)
                        topic_left = topic_left - 1;
                    last = count_body_byte();
                    if (!last && topic_left == 0)
                        st_phase = PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                    part = PART_PAYLOAD;
                    last = count_body_byte();
                end
                PH_OTHER: begin
                    part = PART_OTHER;
                    last = count_body_byte();
                end
                default: begin
                    part = PART_MALFORMED;
                    err  = ERR_OVERRUN;
                    last = count_body_byte();
                end
            endcase
        end
        r.data_byte     = b;
        r.byte_part     = part;
        r.packet_type   = hdr_byte[7:4];
        r.packet_flags  = hdr_byte[3:0];
        r.body_length   = len_acc;
        r.topic_length  = topic_len;
        r.end_of_packet = last;
        r.error_code    = err;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [27:0] exp_val,
                               input logic [27:0] got_val);
        if (exp_val !== got_val) begin
            $error("%s: expected %0h, got %0h", name, exp_val, got_val);
            fail_total++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            body_capacity = LP_CAP_RESET;
            st_phase      = PH_TYPE;
            hdr_byte      = '0;
            len_acc       = '0;
            len_cnt       = '0;
            body_left     = '0;
            topic_len     = '0;
            topic_left    = '0;
            is_halted     = 1'b0;
            expected_tags.delete();
        end else begin
            // the result leaving at this edge is always older than the byte entering
            if (i_pop && !i_empty) begin
                if (expected_tags.size() == 0) begin
                    $error("result with nothing expected: data_byte %0h part %0d",
                           i_tag.data_byte, i_tag.byte_part);
                    fail_total++;
                end else begin
                    want = expected_tags.pop_front();
                    check_field("data_byte", 28'(want.data_byte), 28'(i_tag.data_byte));
                    check_field("byte_part", 28'(want.byte_part), 28'(i_tag.byte_part));
                    check_field("packet_type", 28'(want.packet_type), 28'(i_tag.packet_type));
                    check_field("packet_flags", 28'(want.packet_flags),
                                28'(i_tag.packet_flags));
                    check_field("body_length", want.body_length, i_tag.body_length);
                    check_field("topic_length", 28'(want.topic_length),
                                28'(i_tag.topic_length));
                    check_field("end_of_packet", 28'(want.end_of_packet),
                                28'(i_tag.end_of_packet));
                    check_field("error_code", 28'(want.error_code), 28'(i_tag.error_code));
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == CAP_ADDR)
                body_capacity = i_pwdata[27:0];
            if (i_push && !i_full)
                expected_tags.push_back(predict_tag(i_rx_byte));
        end
        o_pending    <= expected_tags.size();
        o_fail_count <= fail_total;
    end

endmodule

@@ verif/tb_mqtt_packet_deframer_core.sv @@
// testbench top for the mqtt deframer: clock, reset, byte stimulus, config writes and verdict
`timescale 1ns / 100ps

module tb_mqtt_packet_deframer_core;
    import mqttd_pkg::*;

    localparam logic [2:0] ADDR_BODY_CAPACITY = 3'd0;
    localparam int         LONG_HOLD          = 300;
    localparam int         QUIET_LIMIT        = 4000;

    logic        i_clk;
    logic        i_rst_n   = 1'b0;
    logic        push      = 1'b0;
    logic        full;
    logic [7:0]  i_rx_byte = '0;
    logic        empty;
    logic        pop       = 1'b0;
    logic [7:0]  o_data_byte;
    logic [2:0]  o_byte_part;
    logic [3:0]  o_packet_type;
    logic [3:0]  o_packet_flags;
    logic [27:0] o_body_length;
    logic [15:0] o_topic_length;
    logic        o_end_of_packet;
    logic [1:0]  o_error_code;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [2:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    logic [31:0] prdata;
    logic        pready;

    t_result     tag_out;
    int          fail_count;
    int          pending;
    int          send_idle_pct = 0;
    int          pop_stall_pct = 0;
    logic        hold_req      = 1'b0;
    int unsigned quiet_cycles  = 0;
    logic [7:0]  pkt_bytes[$];

    assign tag_out = {o_data_byte, o_byte_part, o_packet_type, o_packet_flags,
                      o_body_length, o_topic_length, o_end_of_packet, o_error_code};

    mqtt_packet_deframer_core u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_rx_byte       (i_rx_byte),
        .empty           (empty),
        .pop             (pop),
        .o_data_byte     (o_data_byte),
        .o_byte_part     (o_byte_part),
        .o_packet_type   (o_packet_type),
        .o_packet_flags  (o_packet_flags),
        .o_body_length   (o_body_length),
        .o_topic_length  (o_topic_length),
        .o_end_of_packet (o_end_of_packet),
        .o_error_code    (o_error_code),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    mqttd_tag_checker #(
        .CAP_ADDR (ADDR_BODY_CAPACITY)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_rx_byte    (i_rx_byte),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_tag        (tag_out),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // result side: random stalls, and a long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                pop <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_req = 1'b0;
            end else
                pop <= ($urandom_range(99) >= pop_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((push && !full) || (pop && !empty) || (psel && penable))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("FAIL");
                $finish;
            end else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push      <= 1'b1;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (full)
            @(posedge i_clk);
    endtask

    task automatic send_queued();
        foreach (pkt_bytes[k])
            send_byte(pkt_bytes[k]);
    endtask

    // stop offering bytes until every predicted item has come out
    task automatic drain();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_BODY_CAPACITY;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // remaining length, 7 bits a byte, optionally padded with empty groups
    task automatic add_length(input int unsigned len, input bit pad);
        int unsigned v;
        int          n;
        logic [7:0]  grp;
        v = len;
        n = 0;
        do begin
            grp = 8'(v & 32'h7F);
            v   = v >> 7;
            if (v != 0)
                grp[7] = 1'b1;
            pkt_bytes.push_back(grp);
            n++;
        end while (v != 0);
        if (pad) begin
            while (n < LP_MAX_LEN_BYTES && $urandom_range(1) == 1) begin
                pkt_bytes[pkt_bytes.size() - 1] = pkt_bytes[pkt_bytes.size() - 1] | 8'h80;
                pkt_bytes.push_back(8'h00);
                n++;
            end
            // continuation left set on the last allowed byte
            if (n == LP_MAX_LEN_BYTES && $urandom_range(1) == 1)
                pkt_bytes[pkt_bytes.size() - 1] = pkt_bytes[pkt_bytes.size() - 1] | 8'h80;
        end
    endtask

    task automatic add_random_packet(input int unsigned max_len);
        int unsigned len;
        int unsigned lim;
        int unsigned tl;
        logic [7:0]  hdr;
        hdr = 8'($urandom);
        if ($urandom_range(1) == 1)
            hdr[7:4] = PKT_PUBLISH;
        lim = (max_len < 40) ? max_len : 40;
        len = ($urandom_range(99) < 85) ? $urandom_range(lim, 0) : $urandom_range(max_len, 0);
        pkt_bytes.push_back(hdr);
        add_length(len, $urandom_range(99) < 20);
        if (hdr[7:4] == PKT_PUBLISH && len >= 2) begin
            // mostly a topic that fits, sometimes one that overruns the body
            if ($urandom_range(99) < 20)
                tl = $urandom_range(65535, len - 1);
            else
                tl = $urandom_range(len - 2, 0);
            pkt_bytes.push_back(tl[15:8]);
            pkt_bytes.push_back(tl[7:0]);
            repeat (len - 2) pkt_bytes.push_back(8'($urandom));
        end else
            repeat (len) pkt_bytes.push_back(8'($urandom));
    endtask

    task automatic run_random(input int unsigned n_bytes, input int unsigned max_len);
        int unsigned sent;
        sent = 0;
        while (sent < n_bytes) begin
            pkt_bytes.delete();
            add_random_packet(max_len);
            sent += pkt_bytes.size();
            send_queued();
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        pkt_bytes = '{
            8'hE0, 8'h00,                                // empty packet
            8'h30, 8'h01, 8'hAA,                         // publish body of a single byte
            8'h32, 8'h05, 8'h00, 8'h02, 8'h61, 8'h62, 8'hFF,
            8'h3B, 8'h03, 8'h00, 8'h02, 8'h11,           // topic longer than the body
            8'h31, 8'h02, 8'hFF, 8'hFF,                  // overrun on the closing byte
            8'h30, 8'h02, 8'h00, 8'h00,                  // empty topic, no payload
            8'hCF, 8'h80, 8'h80, 8'h80, 8'h80            // four length bytes, still continued
        };
        send_queued();

        // reset capacity, no idling, then a long hold-off on the result side
        run_random(30, 300);
        hold_req = 1'b1;
        run_random(40, 40);
        drain();

        write_capacity(32'hFFFF_FFFF);
        send_idle_pct = 62;
        run_random(60, 300);
        drain();

        write_capacity(32'd40);
        send_idle_pct = 0;
        pop_stall_pct = 62;
        run_random(60, 40);
        drain();

        write_capacity(32'd0);
        send_idle_pct = 11;
        pop_stall_pct = 11;
        run_random(16, 0);
        drain();

        write_capacity(32'd60);
        run_random(30, 60);
        // a body exactly at capacity, then one byte over, which halts the block
        pkt_bytes.delete();
        pkt_bytes.push_back(8'h20);
        add_length(60, 1'b0);
        repeat (60) pkt_bytes.push_back(8'($urandom));
        pkt_bytes.push_back(8'h10);
        add_length(61, 1'b0);
        repeat (12) pkt_bytes.push_back(8'($urandom));
        send_queued();
        drain();

        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
